// ===== rtl/core/ppa_pkg.sv =====
package ppa_pkg;

   localparam int PKG_MAX_PARTS = 16;
   localparam int SIZE_BITS     = 16;
   localparam int ID_BITS       = 8;
   localparam int SLOT_BITS     = 4;

   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_PLACE  = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_NOFIT = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      RULE_FIRST = 2'd0,
      RULE_BEST  = 2'd1,
      RULE_WORST = 2'd2,
      RULE_NEXT  = 2'd3
   } rule_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      logic                 kind;
      logic [1:0]           strategy;
      logic [SIZE_BITS-1:0] part_size;
      logic                 occupied;
      logic [ID_BITS-1:0]   proc_id;
      logic [SIZE_BITS-1:0] proc_size;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [SLOT_BITS-1:0] slot;
      logic [SIZE_BITS-1:0] leftover;
   } rsp_type;

   // Search token that walks down the row of cells, one cell per cycle.
   typedef struct packed {
      logic                 valid;
      rule_type             rule;
      logic [SIZE_BITS-1:0] need;
      logic                 found;
      logic [SIZE_BITS-1:0] pick_left;
      logic                 alt_found;
      logic [SIZE_BITS-1:0] alt_left;
   } tok_type;

   // Write command broadcast to all cells.
   typedef struct packed {
      logic                 en;
      logic                 set_size;
      logic [SIZE_BITS-1:0] size;
      logic                 free;
   } wr_type;

endpackage

// ===== rtl/core/partition_placement_allocator_top.sv =====
// Fixed-partition placement allocator.
// An item is accepted on a rising edge where start is high and busy is low.
// An append item adds a partition at the end of the table, free or preloaded.
// A place item searches for a free partition by first, best, worst or next fit
// and marks the chosen one occupied. Every item gives exactly one result on
// rsp_data, marked by a one-cycle pulse on rsp_valid; the receiver cannot
// stall, so each result is taken in the cycle it is shown.
// Each partition lives in one cell of a row of MAX_PARTS cells. A place item
// launches a search token that moves one cell per cycle and carries the best
// candidate so far; the decision and write-back happen as it leaves the last cell.
// Append: the result appears in the cycle after acceptance, and busy stays low,
// so items can follow back to back.
// Place: busy stays high while the token walks down the row, so no new item
// is taken until the search ends; the result is registered as the token leaves
// the last cell.
// Reset clears the table, the partition count and the next-fit rover; the
// block accepts an item in the first cycle after reset is released.
module partition_placement_allocator_top import ppa_pkg::*; #(
   parameter int MAX_PARTS = PKG_MAX_PARTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(MAX_PARTS);
   localparam int CNT_W = $clog2(MAX_PARTS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_PARTS);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] rover_ff, rover_in;
   logic             rover_valid_ff, rover_valid_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   wr_type           wr;
   logic [IDX_W-1:0] wr_idx;
   logic             accept;

   tok_type          tok_chain  [MAX_PARTS+1];
   logic [IDX_W-1:0] pick_chain [MAX_PARTS+1];
   logic [IDX_W-1:0] alt_chain  [MAX_PARTS+1];

   tok_type          tok_last;
   logic [IDX_W-1:0] pick_last, alt_last;

   assign accept   = start && (state_ff == ST_IDLE);
   assign tok_last = tok_chain[MAX_PARTS];
   assign pick_last = pick_chain[MAX_PARTS];
   assign alt_last  = alt_chain[MAX_PARTS];

   // The first cell sees the token in the accept cycle, before start_ff is loaded,
   // so the cells take the start index as it is being set.
   genvar gi;
   generate
      for (gi = 0; gi < MAX_PARTS; gi++) begin : g_cell
         ppa_cell #(
            .MAX_PARTS (MAX_PARTS),
            .CELL_IDX  (gi)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .tok_in    (tok_chain[gi]),
            .pick_in   (pick_chain[gi]),
            .alt_in    (alt_chain[gi]),
            .start_idx (start_in),
            .wr        (wr),
            .wr_idx    (wr_idx),
            .tok_out   (tok_chain[gi+1]),
            .pick_out  (pick_chain[gi+1]),
            .alt_out   (alt_chain[gi+1])
         );
      end
   endgenerate

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rover_in       = rover_ff;
      rover_valid_in = rover_valid_ff;
      start_in       = start_ff;
      rsp_valid_in   = 1'b0;
      rsp_data_in    = rsp_data_ff;
      wr             = '0;
      wr_idx         = '0;

      tok_chain[0]           = '0;
      tok_chain[0].rule      = rule_type'(req_data.strategy);
      tok_chain[0].need      = req_data.proc_size;
      pick_chain[0]          = '0;
      alt_chain[0]           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.kind == KIND_APPEND) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  if (count_ff == FULL_COUNT) begin
                     rsp_data_in.status = STATUS_FULL;
                  end else begin
                     wr.en              = 1'b1;
                     wr.set_size        = 1'b1;
                     wr.size            = req_data.part_size;
                     wr.free            = !req_data.occupied;
                     wr_idx             = count_ff[IDX_W-1:0];
                     count_in           = count_ff + CNT_W'(1);
                     rsp_data_in.status = STATUS_DONE;
                     rsp_data_in.slot   = SLOT_BITS'(count_ff);
                  end
               end else begin
                  tok_chain[0].valid = 1'b1;
                  // A stale rover, or none yet, starts next fit at the first entry.
                  if (rover_valid_ff && ({1'b0, rover_ff} < (IDX_W + 1)'(count_ff))) begin
                     start_in = rover_ff;
                  end else begin
                     start_in = '0;
                  end
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (tok_last.valid) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               wr.set_size  = 1'b0;
               wr.free      = 1'b0;
               if (tok_last.found) begin
                  wr.en                = 1'b1;
                  wr_idx               = pick_last;
                  rsp_data_in.status   = STATUS_DONE;
                  rsp_data_in.slot     = SLOT_BITS'(pick_last);
                  rsp_data_in.leftover = tok_last.pick_left;
               end else if ((tok_last.rule == RULE_NEXT) && tok_last.alt_found) begin
                  wr.en                = 1'b1;
                  wr_idx               = alt_last;
                  rsp_data_in.status   = STATUS_DONE;
                  rsp_data_in.slot     = SLOT_BITS'(alt_last);
                  rsp_data_in.leftover = tok_last.alt_left;
               end else begin
                  rsp_data_in.status = STATUS_NOFIT;
               end
               if (wr.en && (tok_last.rule == RULE_NEXT)) begin
                  rover_in       = wr_idx;
                  rover_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         rover_ff       <= '0;
         rover_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         rover_ff       <= rover_in;
         rover_valid_ff <= rover_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff == ST_SCAN);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/ppa_cell.sv =====
module ppa_cell import ppa_pkg::*; #(
   parameter int MAX_PARTS = PKG_MAX_PARTS,
   parameter int CELL_IDX  = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tok_type                      tok_in,
   input  logic [$clog2(MAX_PARTS)-1:0] pick_in,
   input  logic [$clog2(MAX_PARTS)-1:0] alt_in,
   input  logic [$clog2(MAX_PARTS)-1:0] start_idx,
   input  wr_type                       wr,
   input  logic [$clog2(MAX_PARTS)-1:0] wr_idx,
   output tok_type                      tok_out,
   output logic [$clog2(MAX_PARTS)-1:0] pick_out,
   output logic [$clog2(MAX_PARTS)-1:0] alt_out
);

   localparam int IDX_W = $clog2(MAX_PARTS);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic [SIZE_BITS-1:0] size_ff;
   logic                 free_ff;
   tok_type              tok_ff, tok_in_next;
   logic [IDX_W-1:0]     pick_ff, alt_ff;
   logic [IDX_W-1:0]     pick_in_next, alt_in_next;
   logic                 fit, take, alt_take, at_or_after_start;
   logic [SIZE_BITS-1:0] left;

   always_comb begin
      fit               = tok_in.valid && free_ff && (size_ff >= tok_in.need);
      left              = size_ff - tok_in.need;
      at_or_after_start = (MY_IDX >= start_idx);
      case (tok_in.rule)
         RULE_FIRST: take = fit && !tok_in.found;
         RULE_BEST:  take = fit && (!tok_in.found || (left < tok_in.pick_left));
         RULE_WORST: take = fit && (!tok_in.found || (left > tok_in.pick_left));
         RULE_NEXT:  take = fit && !tok_in.found && at_or_after_start;
         default:    take = 1'b0;
      endcase
      // Next fit also remembers the first fit anywhere, used when the scan wraps.
      alt_take = fit && (tok_in.rule == RULE_NEXT) && !tok_in.alt_found;

      tok_in_next  = tok_in;
      pick_in_next = pick_in;
      alt_in_next  = alt_in;
      if (take) begin
         tok_in_next.found     = 1'b1;
         tok_in_next.pick_left = left;
         pick_in_next          = MY_IDX;
      end
      if (alt_take) begin
         tok_in_next.alt_found = 1'b1;
         tok_in_next.alt_left  = left;
         alt_in_next           = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         if (wr.en && (wr_idx == MY_IDX)) begin
            free_ff <= wr.free;
         end
         tok_ff.valid <= tok_in_next.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.set_size && (wr_idx == MY_IDX)) begin
         size_ff <= wr.size;
      end
      tok_ff.rule      <= tok_in_next.rule;
      tok_ff.need      <= tok_in_next.need;
      tok_ff.found     <= tok_in_next.found;
      tok_ff.pick_left <= tok_in_next.pick_left;
      tok_ff.alt_found <= tok_in_next.alt_found;
      tok_ff.alt_left  <= tok_in_next.alt_left;
      pick_ff          <= pick_in_next;
      alt_ff           <= alt_in_next;
   end

   assign tok_out  = tok_ff;
   assign pick_out = pick_ff;
   assign alt_out  = alt_ff;

endmodule

// ===== rtl/core/ppa_check.sv =====
module ppa_check import ppa_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // Only the three defined status codes are ever reported.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_DONE) || (rsp_data.status == STATUS_NOFIT) ||
                    (rsp_data.status == STATUS_FULL))
      else $error("undefined status code");

   // A failed item reports slot and leftover as zero.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_DONE)) |->
         ((rsp_data.slot == '0) && (rsp_data.leftover == '0)))
      else $error("failed item has nonzero slot or leftover");

   // The block only becomes busy after accepting an item.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted item");

   // The end of a search always delivers its result.
   a_scan_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("search ended without a result");

   // An append answers in the next cycle.
   a_append_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.kind == KIND_APPEND)) |=> rsp_valid)
      else $error("append item gave no result in the next cycle");

endmodule

bind partition_placement_allocator_top ppa_check u_ppa_check (.*);
